@@ design/smfs_pkg.sv @@
`default_nettype none
package smfs_pkg;

  localparam int COORD_W = 32;
  localparam int ACC_W   = 88;
  localparam int DEN_W   = 42;
  localparam int RAD_W   = 64;
  localparam int RES_W   = 32;

  typedef struct packed {
    logic               go;
    logic               clr;
    logic               neg;
    logic               hi;
    logic [RES_W-1:0]   a;
    logic [RES_W-1:0]   b;
  } mac_op_t;

  typedef struct packed {
    logic               start;
    logic               sqrt_mode;
    logic [RAD_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } dsu_req_t;

  typedef struct packed {
    logic               done;
    logic [RES_W-1:0]   res;
  } dsu_rsp_t;

endpackage
`default_nettype wire

@@ design/smfs_mac.sv @@
`default_nettype none
module smfs_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  smfs_pkg::mac_op_t                   op,
  output logic signed [smfs_pkg::ACC_W-1:0]   acc
);
  import smfs_pkg::*;

  logic                      pv;
  logic                      pneg;
  logic                      phi;
  logic                      pclr;
  logic [2*RES_W-1:0]        prod;
  logic signed [ACC_W-1:0]   ext;
  logic signed [ACC_W-1:0]   term;

  // partial product, then signed accumulate with optional 32-bit weight
  always_comb begin
    ext = signed'({{(ACC_W-2*RES_W){1'b0}}, prod});
    if (phi) begin
      ext = ext <<< RES_W;
    end
    term = pneg ? -ext : ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= op.go;
    end
    prod <= op.a * op.b;
    pneg <= op.neg;
    phi  <= op.hi;
    pclr <= op.clr;
    if (pv) begin
      acc <= (pclr ? '0 : acc) + term;
    end
  end

endmodule
`default_nettype wire

@@ design/smfs_dsu.sv @@
`default_nettype none
module smfs_dsu (
  input  logic                 clk,
  input  logic                 rst,
  input  smfs_pkg::dsu_req_t   req,
  output smfs_pkg::dsu_rsp_t   rsp
);
  import smfs_pkg::*;

  logic               busy;
  logic               done;
  logic               sq;
  logic [4:0]         cnt;
  logic [DEN_W:0]     rem;
  logic [RAD_W-1:0]   nn;
  logic [DEN_W-1:0]   den;
  logic [RES_W-1:0]   res;
  logic [DEN_W+1:0]   mnd;
  logic [DEN_W+1:0]   sbt;
  logic [DEN_W+1:0]   dif;
  logic               ge;

  // one shared trial subtract: two radicand bits per step for root, one for divide
  always_comb begin
    if (sq) begin
      mnd = {9'b0, rem[32:0], nn[RAD_W-1 -: 2]};
      sbt = {10'b0, res, 2'b01};
    end else begin
      mnd = {rem, nn[RAD_W-1]};
      sbt = {2'b0, den};
    end
    dif = mnd - sbt;
    ge  = (mnd >= sbt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 5'd31)) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      sq  <= req.sqrt_mode;
      cnt <= '0;
      den <= req.den;
      res <= '0;
      if (req.sqrt_mode) begin
        rem <= '0;
        nn  <= req.num;
      end else begin
        rem <= {11'b0, req.num[RAD_W-1:RES_W]};
        nn  <= {req.num[RES_W-1:0], {RES_W{1'b0}}};
      end
    end else if (busy) begin
      rem <= ge ? dif[DEN_W:0] : mnd[DEN_W:0];
      res <= {res[RES_W-2:0], ge};
      nn  <= sq ? (nn << 2) : (nn << 1);
      cnt <= cnt + 5'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule
`default_nettype wire

@@ design/segment_magnetic_field_sum.sv @@
// A segment's time is set by seven 32-step passes of the shared divide/root unit (none if
//   singular), the multiply-accumulate groups and the normalizing shifts; a last vertex
//   adds the emit state, which waits for a free output register.
// Throughput: one item in flight; s_tready drops until it finishes and its beat is loaded.
// Reset: synchronous active-high rst clears control, path state and config to
//   current = 1.0, observation point = origin.
`default_nettype none
module segment_magnetic_field_sum (
  input  logic          clk,
  input  logic          rst,
  // config write port: 0 current, 1 obs_x, 2 obs_y, 3 obs_z
  input  logic          cfg_wen,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // vert_x[31:0], vert_y[63:32], vert_z[95:64]
  input  logic          s_tuser,   // first_vertex
  input  logic          s_tlast,   // last_vertex
  output logic          m_tvalid,
  input  logic          m_tready,
  // field_x[47:0], field_y[95:48], field_z[143:96], singular_seen[144],
  // saturated[145], zero pad [151:146]
  output logic [151:0]  m_tdata
);
  import smfs_pkg::*;

  localparam logic [31:0] INV4PI = 32'd341782638;
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM_S, ST_MUL, ST_MWAIT, ST_MTAKE, ST_CHK, ST_USTART,
    ST_UWAIT, ST_NORM_T, ST_FSHIFT, ST_FADD, ST_FIN, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    G_BB, G_CC, G_X0, G_X1, G_X2, G_AB, G_AC, G_D, G_V, G_W, G_F
  } grp_t;

  typedef enum logic [2:0] {
    U_SQB, U_SQC, U_DVB, U_DVC, U_DVU
  } uop_t;

  state_t                   state;
  grp_t                     grp;
  uop_t                     uop;
  logic [1:0]               k;
  logic [1:0]               ci;

  logic [31:0]              cur_r;
  logic signed [31:0]       obs_r [3];
  logic signed [31:0]       prev_r [3];
  logic signed [47:0]       sum_r [3];
  logic                     have_prev;
  logic                     sing_f;
  logic                     sat_f;
  logic                     pend_last;

  logic signed [33:0]       vv [9];
  logic [32:0]              vm [9];
  logic [3:0]               s_sh;
  logic [41:0]              bb_r;
  logic [41:0]              cc_r;
  logic signed [42:0]       xs [3];
  logic [41:0]              xm [3];
  logic signed [42:0]       ab_r;
  logic signed [42:0]       ac_r;
  logic [31:0]              nb_r;
  logic [31:0]              nc_r;
  logic [31:0]              qb_r;
  logic [32:0]              r_mag;
  logic                     r_neg;
  logic signed [5:0]        t_sh;
  logic [41:0]              d_r;
  logic [31:0]              um_r;
  logic [54:0]              vmag;
  logic [51:0]              wmag;
  logic [83:0]              p_r;
  logic [46:0]              f_r;
  logic                     f_ovf;
  logic                     f_neg;

  mac_op_t                  mac_op;
  logic signed [ACC_W-1:0]  acc;
  dsu_req_t                 dreq;
  dsu_rsp_t                 drsp;

  logic signed [31:0]       pin [3];
  logic                     accept;
  logic                     slot_free;
  logic signed [33:0]       xo;
  logic signed [33:0]       yo;
  logic                     sub;
  logic [1:0]               klast;
  logic signed [42:0]       xc;
  logic signed [42:0]       xd;
  logic [42:0]              xc_mag;
  logic [42:0]              xd_mag;
  logic [42:0]              ab_mag;
  logic [42:0]              ac_mag;
  logic signed [33:0]       qcs;
  logic signed [33:0]       qbs;
  logic signed [33:0]       rr;
  logic signed [7:0]        sh;
  logic [83:0]              shifted;
  logic signed [47:0]       sum_sel;
  logic signed [48:0]       sum49;
  logic                     sum_hi;
  logic                     sum_lo;
  logic                     big_s;
  logic                     big_t;
  logic                     small_t;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [42:0] mag43(input logic signed [42:0] v);
    mag43 = v[42] ? 43'(-v) : 43'(v);
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    sx34 = {{2{v[31]}}, v};
  endfunction

  assign pin[0]    = s_tdata[31:0];
  assign pin[1]    = s_tdata[63:32];
  assign pin[2]    = s_tdata[95:64];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // pick the component that the current pass works on
  always_comb begin
    unique case (ci)
      2'd0:    begin xc = xs[0]; sum_sel = sum_r[0]; end
      2'd1:    begin xc = xs[1]; sum_sel = sum_r[1]; end
      default: begin xc = xs[2]; sum_sel = sum_r[2]; end
    endcase
    unique case (k)
      2'd0:    xd = xs[0];
      2'd1:    xd = xs[1];
      default: xd = xs[2];
    endcase
    xc_mag = mag43(xc);
    xd_mag = mag43(xd);
    ab_mag = mag43(ab_r);
    ac_mag = mag43(ac_r);
  end

  // operand table of the multiply-accumulate groups
  always_comb begin
    xo    = '0;
    yo    = '0;
    sub   = 1'b0;
    klast = 2'd2;
    unique case (grp)
      G_BB: begin
        unique case (k)
          2'd0:    begin xo = vv[3]; yo = vv[3]; end
          2'd1:    begin xo = vv[4]; yo = vv[4]; end
          default: begin xo = vv[5]; yo = vv[5]; end
        endcase
      end
      G_CC: begin
        unique case (k)
          2'd0:    begin xo = vv[6]; yo = vv[6]; end
          2'd1:    begin xo = vv[7]; yo = vv[7]; end
          default: begin xo = vv[8]; yo = vv[8]; end
        endcase
      end
      G_X0: begin
        klast = 2'd1;
        if (k == 2'd0) begin
          xo = vv[2]; yo = vv[7];
        end else begin
          xo = vv[1]; yo = vv[8]; sub = 1'b1;
        end
      end
      G_X1: begin
        klast = 2'd1;
        if (k == 2'd0) begin
          xo = vv[0]; yo = vv[8];
        end else begin
          xo = vv[2]; yo = vv[6]; sub = 1'b1;
        end
      end
      G_X2: begin
        klast = 2'd1;
        if (k == 2'd0) begin
          xo = vv[6]; yo = vv[1];
        end else begin
          xo = vv[7]; yo = vv[0]; sub = 1'b1;
        end
      end
      G_AB: begin
        unique case (k)
          2'd0:    begin xo = vv[0]; yo = vv[3]; end
          2'd1:    begin xo = vv[1]; yo = vv[4]; end
          default: begin xo = vv[2]; yo = vv[5]; end
        endcase
      end
      G_AC: begin
        unique case (k)
          2'd0:    begin xo = vv[0]; yo = vv[6]; end
          2'd1:    begin xo = vv[1]; yo = vv[7]; end
          default: begin xo = vv[2]; yo = vv[8]; end
        endcase
      end
      default: klast = (grp == G_D) ? 2'd2 : 2'd1;
    endcase

    mac_op.go  = (state == ST_MUL);
    mac_op.clr = (k == 2'd0);
    mac_op.hi  = 1'b0;
    mac_op.neg = xo[33] ^ yo[33] ^ sub;
    mac_op.a   = 32'(mag34(xo));
    mac_op.b   = 32'(mag34(yo));
    unique case (grp)
      G_D: begin
        mac_op.neg = 1'b0;
        mac_op.a   = xd_mag[31:0];
        mac_op.b   = xd_mag[31:0];
      end
      G_V: begin
        mac_op.neg = 1'b0;
        mac_op.hi  = k[0];
        mac_op.a   = um_r;
        mac_op.b   = k[0] ? {31'b0, r_mag[32]} : r_mag[31:0];
      end
      G_W: begin
        mac_op.neg = 1'b0;
        mac_op.hi  = k[0];
        mac_op.a   = k[0] ? {9'b0, vmag[54:32]} : vmag[31:0];
        mac_op.b   = INV4PI;
      end
      G_F: begin
        mac_op.neg = 1'b0;
        mac_op.hi  = k[0];
        mac_op.a   = k[0] ? {12'b0, wmag[51:32]} : wmag[31:0];
        mac_op.b   = cur_r[31] ? 32'(-cur_r) : cur_r;
      end
      default: ;
    endcase
  end

  // divide / square-root requests
  always_comb begin
    dreq.start     = (state == ST_USTART);
    dreq.sqrt_mode = (uop == U_SQB) || (uop == U_SQC);
    unique case (uop)
      U_SQB:   begin dreq.num = {bb_r, 22'b0};            dreq.den = '0; end
      U_SQC:   begin dreq.num = {cc_r, 22'b0};            dreq.den = '0; end
      U_DVB:   begin dreq.num = {ab_mag[41:0], 22'b0};    dreq.den = {10'b0, nb_r}; end
      U_DVC:   begin dreq.num = {ac_mag[41:0], 22'b0};    dreq.den = {10'b0, nc_r}; end
      default: begin dreq.num = {3'b0, xc_mag[20:0], 40'b0}; dreq.den = d_r; end
    endcase
  end

  // signed difference of the two projections, scale shift, final add, normalization tests
  always_comb begin
    qcs     = ac_r[42] ? -signed'({2'b0, drsp.res}) : signed'({2'b0, drsp.res});
    qbs     = ab_r[42] ? -signed'({2'b0, qb_r}) : signed'({2'b0, qb_r});
    rr      = qcs - qbs;
    sh      = 8'sd27 + {{2{t_sh[5]}}, t_sh} + signed'({4'b0, s_sh});
    shifted = p_r >> sh[5:0];
    sum49   = f_neg ? ({sum_sel[47], sum_sel} - signed'({2'b0, f_r}))
                    : ({sum_sel[47], sum_sel} + signed'({2'b0, f_r}));
    sum_hi  = !sum49[48] && sum49[47];
    sum_lo  = sum49[48] && !sum49[47];
    big_s   = 1'b0;
    for (int i = 0; i < 9; i++) begin
      big_s = big_s | (vm[i][32:20] != '0);
    end
    big_t   = 1'b0;
    small_t = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big_t   = big_t | (xm[i][41:20] != '0);
      small_t = small_t & (xm[i][41:19] == '0);
    end
  end

  smfs_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .acc (acc)
  );

  smfs_dsu u_dsu (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grp       <= G_BB;
      uop       <= U_SQB;
      k         <= '0;
      ci        <= '0;
      cur_r     <= 32'd65536;
      have_prev <= 1'b0;
      sing_f    <= 1'b0;
      sat_f     <= 1'b0;
      pend_last <= 1'b0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        obs_r[i]  <= '0;
        prev_r[i] <= '0;
        sum_r[i]  <= '0;
      end
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          2'd0:    cur_r    <= cfg_wdata;
          2'd1:    obs_r[0] <= cfg_wdata;
          2'd2:    obs_r[1] <= cfg_wdata;
          default: obs_r[2] <= cfg_wdata;
        endcase
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_last <= s_tlast;
            for (int i = 0; i < 3; i++) begin
              prev_r[i] <= pin[i];
            end
            if (s_tuser || !have_prev) begin
              // start a new path: drop old sums and flags
              have_prev <= 1'b1;
              sing_f    <= 1'b0;
              sat_f     <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                sum_r[i] <= '0;
              end
              state <= s_tlast ? ST_EMIT : ST_IDLE;
            end else begin
              for (int i = 0; i < 3; i++) begin
                vv[i]     <= sx34(pin[i]) - sx34(prev_r[i]);
                vv[3 + i] <= sx34(pin[i]) - sx34(obs_r[i]);
                vv[6 + i] <= sx34(prev_r[i]) - sx34(obs_r[i]);
                vm[i]     <= 33'(mag34(sx34(pin[i]) - sx34(prev_r[i])));
                vm[3 + i] <= 33'(mag34(sx34(pin[i]) - sx34(obs_r[i])));
                vm[6 + i] <= 33'(mag34(sx34(prev_r[i]) - sx34(obs_r[i])));
              end
              s_sh  <= '0;
              state <= ST_NORM_S;
            end
          end
        end

        ST_NORM_S: begin
          // halve all nine until every magnitude fits in 20 bits
          if (big_s) begin
            for (int i = 0; i < 9; i++) begin
              vv[i] <= vv[i] >>> 1;
              vm[i] <= vm[i] >> 1;
            end
            s_sh <= s_sh + 4'd1;
          end else begin
            grp   <= G_BB;
            k     <= '0;
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          if (k == klast) begin
            k     <= '0;
            state <= ST_MWAIT;
          end else begin
            k <= k + 2'd1;
          end
        end

        ST_MWAIT: state <= ST_MTAKE;

        ST_MTAKE: begin
          k     <= '0;
          state <= ST_MUL;
          unique case (grp)
            G_BB: begin bb_r <= acc[41:0]; grp <= G_CC; end
            G_CC: begin cc_r <= acc[41:0]; grp <= G_X0; end
            G_X0: begin
              xs[0] <= acc[42:0]; xm[0] <= 42'(mag43(acc[42:0])); grp <= G_X1;
            end
            G_X1: begin
              xs[1] <= acc[42:0]; xm[1] <= 42'(mag43(acc[42:0])); grp <= G_X2;
            end
            G_X2: begin
              xs[2] <= acc[42:0]; xm[2] <= 42'(mag43(acc[42:0]));
              state <= ST_CHK;
            end
            G_AB: begin ab_r <= acc[42:0]; grp <= G_AC; end
            G_AC: begin
              ac_r  <= acc[42:0];
              uop   <= U_SQB;
              state <= ST_USTART;
            end
            G_D: begin
              d_r   <= acc[41:0];
              ci    <= '0;
              uop   <= U_DVU;
              state <= ST_USTART;
            end
            G_V: begin vmag <= acc[54:0]; grp <= G_W; end
            G_W: begin wmag <= acc[83:32]; grp <= G_F; end
            default: begin
              p_r   <= acc[83:0];
              state <= ST_FSHIFT;
            end
          endcase
        end

        ST_CHK: begin
          // zero denominator: segment adds nothing
          if ((bb_r == '0) || (cc_r == '0) ||
              ((xs[0] == '0) && (xs[1] == '0) && (xs[2] == '0))) begin
            sing_f <= 1'b1;
            state  <= ST_FIN;
          end else begin
            grp   <= G_AB;
            k     <= '0;
            state <= ST_MUL;
          end
        end

        ST_USTART: state <= ST_UWAIT;

        ST_UWAIT: begin
          if (drsp.done) begin
            unique case (uop)
              U_SQB: begin nb_r <= drsp.res; uop <= U_SQC; state <= ST_USTART; end
              U_SQC: begin nc_r <= drsp.res; uop <= U_DVB; state <= ST_USTART; end
              U_DVB: begin qb_r <= drsp.res; uop <= U_DVC; state <= ST_USTART; end
              U_DVC: begin
                r_neg <= rr[33];
                r_mag <= 33'(mag34(rr));
                t_sh  <= '0;
                state <= ST_NORM_T;
              end
              default: begin
                um_r  <= drsp.res;
                grp   <= G_V;
                k     <= '0;
                state <= ST_MUL;
              end
            endcase
          end
        end

        ST_NORM_T: begin
          // bring the largest cross-product magnitude into [2^19, 2^20)
          if (big_t) begin
            for (int i = 0; i < 3; i++) begin
              xs[i] <= xs[i] >>> 1;
              xm[i] <= xm[i] >> 1;
            end
            t_sh <= t_sh + 6'sd1;
          end else if (small_t) begin
            for (int i = 0; i < 3; i++) begin
              xs[i] <= xs[i] <<< 1;
              xm[i] <= xm[i] << 1;
            end
            t_sh <= t_sh - 6'sd1;
          end else begin
            grp   <= G_D;
            k     <= '0;
            state <= ST_MUL;
          end
        end

        ST_FSHIFT: begin
          f_ovf <= (shifted[83:47] != '0);
          f_r   <= (shifted[83:47] != '0) ? SUM_MAX[46:0] : shifted[46:0];
          f_neg <= xc[42] ^ r_neg ^ cur_r[31];
          state <= ST_FADD;
        end

        ST_FADD: begin
          if (sum_hi) begin
            sum_r[ci] <= SUM_MAX;
          end else if (sum_lo) begin
            sum_r[ci] <= SUM_MIN;
          end else begin
            sum_r[ci] <= sum49[47:0];
          end
          sat_f <= sat_f | f_ovf | sum_hi | sum_lo;
          if (ci == 2'd2) begin
            state <= ST_FIN;
          end else begin
            ci    <= ci + 2'd1;
            uop   <= U_DVU;
            state <= ST_USTART;
          end
        end

        ST_FIN: state <= pend_last ? ST_EMIT : ST_IDLE;

        ST_EMIT: begin
          // hold until the output register is free, then release the path
          if (slot_free) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {6'b0, sat_f, sing_f, sum_r[2], sum_r[1], sum_r[0]};
            have_prev <= 1'b0;
            sing_f    <= 1'b0;
            sat_f     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i]  <= '0;
              prev_r[i] <= '0;
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // the divide/root unit reports only to a sequencer that waits for it
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == ST_UWAIT))
    else $error("divide/root result arrived outside the wait state");

  // emitting a result always closes the path
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free) |=> (m_tvalid && !have_prev && !sing_f && !sat_f))
    else $error("path not closed after emitting its field");

  // input differences are at most 33 bits, so 13 halvings always suffice
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM_S) |-> (s_sh <= 4'd13))
    else $error("input normalization shift out of range");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
module tb;

  localparam int  SEG_CYCLES = 400;     // worst segment latency, with margin
  localparam int  STALL_LIMIT = 20000;  // cycles without any beat before giving up
  localparam int  RAND_PATHS_PER_PHASE = 65;
  localparam int  NUM_PHASES = 8;
  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);
  localparam longint unsigned INV4PI_Q32 = 64'd341782638;

  // register indexes of the write port
  typedef enum logic [1:0] {
    REG_CURRENT = 2'd0,
    REG_OBS_X   = 2'd1,
    REG_OBS_Y   = 2'd2,
    REG_OBS_Z   = 2'd3
  } reg_index_e;

  // result beat as it sits on m_tdata, top field first
  typedef struct packed {
    logic [5:0]  pad;
    logic        sat;
    logic        sing;
    logic [47:0] fz;
    logic [47:0] fy;
    logic [47:0] fx;
  } field_beat_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    bit                 first, last;
    bit                 known;   // expected result typed in below
    field_beat_t        res;
  } vertex_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;  // vert_x, vert_y, vert_z from bit 0 up
  logic         s_tuser = 1'b0; // first_vertex
  logic         s_tlast = 1'b0; // last_vertex
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;       // field_x, field_y, field_z, singular_seen, saturated, pad

  segment_magnetic_field_sum u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Field predictor: own copy of config and path state
  // ---------------------------------------------------------------------------
  logic signed [31:0] cur_amp;
  logic signed [31:0] obs_pt [3];
  longint             prev_v [3];
  longint             sum_f [3];
  bit                 have_prev, sing_f, sat_f;

  field_beat_t field_q [$];
  int          errors = 0;
  bit          calm = 1'b0;   // no idling on either side

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // (x*y) >> sh on a full 128-bit product, clipped to lim
  function automatic longint unsigned mul_shift(longint unsigned x, longint unsigned y,
                                                int sh, longint unsigned lim,
                                                inout bit ovf);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p >> sh;
    if (p[127:64] != 0 || p[63:0] > lim) begin
      ovf = 1'b1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic longint scaled_quot(longint num, longint unsigned den);
    longint unsigned q;
    q = (mag64(num) << 22) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void add_segment(longint p1 [3]);
    longint v [9];
    longint xp [3];
    longint bb, cc, ab, ac, rr, u, vv, sum, cur;
    longint unsigned m, mx, dd, nb, nc, um, w, f;
    int s, t;
    bit neg, ovf;
    m = 0; mx = 0; dd = 0; s = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      v[i]     = p1[i] - prev_v[i];
      v[3 + i] = p1[i] - longint'(obs_pt[i]);
      v[6 + i] = prev_v[i] - longint'(obs_pt[i]);
    end
    for (int i = 0; i < 9; i++) if (mag64(v[i]) > m) m = mag64(v[i]);
    while ((m >> s) >= 64'd1 << 20) s++;
    for (int i = 0; i < 9; i++) v[i] = v[i] >>> s;
    // A = v[0..2], B = v[3..5], C = v[6..8]
    bb = v[3] * v[3] + v[4] * v[4] + v[5] * v[5];
    cc = v[6] * v[6] + v[7] * v[7] + v[8] * v[8];
    xp[0] = v[2] * v[7] - v[1] * v[8];
    xp[1] = v[0] * v[8] - v[2] * v[6];
    xp[2] = v[6] * v[1] - v[7] * v[0];
    if (bb == 0 || cc == 0 || (xp[0] == 0 && xp[1] == 0 && xp[2] == 0)) begin
      sing_f = 1'b1;
      return;
    end
    ab = v[0] * v[3] + v[1] * v[4] + v[2] * v[5];
    ac = v[0] * v[6] + v[1] * v[7] + v[2] * v[8];
    nb = isqrt(longint'(bb) << 22);
    nc = isqrt(longint'(cc) << 22);
    rr = scaled_quot(ac, nc) - scaled_quot(ab, nb);
    for (int i = 0; i < 3; i++) if (mag64(xp[i]) > mx) mx = mag64(xp[i]);
    if (mx >= 64'd1 << 20) begin
      while ((mx >> t) >= 64'd1 << 20) t++;
      for (int i = 0; i < 3; i++) xp[i] = xp[i] >>> t;
    end else begin
      while (mx < 64'd1 << 19) begin
        mx <<= 1;
        t--;
      end
      for (int i = 0; i < 3; i++) xp[i] = xp[i] * (64'sd1 <<< (-t));
    end
    for (int i = 0; i < 3; i++) dd += xp[i] * xp[i];
    cur = cur_amp;
    for (int i = 0; i < 3; i++) begin
      um  = (mag64(xp[i]) << 40) / dd;
      u   = (xp[i] < 0) ? -longint'(um) : longint'(um);
      vv  = u * rr;
      neg = (vv < 0) != (cur < 0);
      ovf = 1'b0;
      w   = mul_shift(mag64(vv), INV4PI_Q32, 32, '1, ovf);
      f   = mul_shift(w, mag64(cur), 27 + t + s, SUM_MAX, ovf);
      sum = sum_f[i] + (neg ? -longint'(f) : longint'(f));
      if (ovf) sat_f = 1'b1;
      if (sum > SUM_MAX) begin
        sum = SUM_MAX;
        sat_f = 1'b1;
      end else if (sum < SUM_MIN) begin
        sum = SUM_MIN;
        sat_f = 1'b1;
      end
      sum_f[i] = sum;
    end
  endfunction

  function automatic void clear_path();
    for (int i = 0; i < 3; i++) sum_f[i] = 0;
    sing_f = 1'b0;
    sat_f = 1'b0;
  endfunction

  // Advance the path by one vertex; returns 1 when it emits a summed field.
  function automatic bit predict_vertex(vertex_row_t r, output field_beat_t res);
    longint p [3];
    p[0] = r.x; p[1] = r.y; p[2] = r.z;
    res = '0;
    if (r.first || !have_prev) begin
      clear_path();
      have_prev = 1'b1;
    end else begin
      add_segment(p);
    end
    for (int i = 0; i < 3; i++) prev_v[i] = p[i];
    if (!r.last) return 1'b0;
    res.fx = sum_f[0][47:0];
    res.fy = sum_f[1][47:0];
    res.fz = sum_f[2][47:0];
    res.sing = sing_f;
    res.sat = sat_f;
    have_prev = 1'b0;
    for (int i = 0; i < 3; i++) prev_v[i] = 0;
    clear_path();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    field_beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = field_beat_t'(m_tdata);
      if (field_q.size() == 0) begin
        report("unexpected beat, field_x", got.fx, 48'd0);
      end else begin
        want = field_q.pop_front();
        if (got.fx !== want.fx) report("field_x", got.fx, want.fx);
        if (got.fy !== want.fy) report("field_y", got.fy, want.fy);
        if (got.fz !== want.fz) report("field_z", got.fz, want.fz);
        if (got.sing !== want.sing) report("singular_seen", got.sing, want.sing);
        if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
        if (got.pad !== 6'd0) report("pad", got.pad, 48'd0);
      end
    end
  end

  // Receiver: stall in random bursts unless the run is calm.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Hold the vertex on the bus until accepted; leave tvalid high for the caller.
  task automatic send_vertex(vertex_row_t r);
    field_beat_t res;
    bit emits;
    s_tvalid <= 1'b1;
    s_tdata  <= {r.z, r.y, r.x};
    s_tuser  <= r.first;
    s_tlast  <= r.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    emits = predict_vertex(r, res);
    if (emits) field_q.push_back(r.known ? r.res : res);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drop tvalid, drain all results, then let any trailing segment finish.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (field_q.size() != 0) @(posedge clk);
    repeat (SEG_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] amp, logic [31:0] ox, logic [31:0] oy,
                              logic [31:0] oz);
    reg_index_e idx [4];
    logic [31:0] val [4];
    idx = '{REG_CURRENT, REG_OBS_X, REG_OBS_Y, REG_OBS_Z};
    val = '{amp, ox, oy, oz};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    cur_amp = amp;
    obs_pt[0] = ox; obs_pt[1] = oy; obs_pt[2] = oz;
  endtask

  function automatic logic [31:0] rand_coord(logic signed [31:0] near);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return near + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return near + $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic random_path();
    vertex_row_t r;
    int len;
    bit noise;
    len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
    noise = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      r.known = 1'b0;
      r.res = '0;
      if (k > 0 && $urandom_range(0, 11) == 0) begin
        // repeat the previous vertex: a degenerate segment
        r.x = prev_v[0]; r.y = prev_v[1]; r.z = prev_v[2];
      end else begin
        r.x = rand_coord(obs_pt[0]);
        r.y = rand_coord(obs_pt[1]);
        r.z = rand_coord(obs_pt[2]);
      end
      r.first = noise ? $urandom_range(0, 1) : (k == 0);
      r.last  = noise ? ($urandom_range(0, 3) == 0) : (k == len - 1);
      send_vertex(r);
      maybe_gap();
    end
  endtask

  localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam field_beat_t NO_FIELD  = '0;
  localparam field_beat_t SING_ONLY = '{pad: '0, sat: 1'b0, sing: 1'b1,
                                        fz: '0, fy: '0, fx: '0};

  vertex_row_t directed [] = '{
    // one-vertex paths at the coordinate extremes emit zeros
    '{MAXC, MAXC, MAXC, 1, 1, 1, NO_FIELD},
    '{MINC, MINC, MINC, 1, 1, 1, NO_FIELD},
    // repeated vertex: zero-length segment
    '{ONE, 0, 0, 1, 0, 0, NO_FIELD},
    '{ONE, 0, 0, 0, 1, 1, SING_ONLY},
    // a two-segment path around the origin
    '{ONE, 0, 0, 1, 0, 0, NO_FIELD},
    '{0, ONE, 0, 0, 0, 0, NO_FIELD},
    '{0, 0, ONE, 0, 1, 0, NO_FIELD},
    // no first mark after a finished path: starts one anyway
    '{ONE, ONE, 0, 0, 0, 0, NO_FIELD},
    '{-ONE, ONE, 0, 0, 1, 0, NO_FIELD},
    // segment across the whole coordinate range
    '{MINC, MINC, MINC, 1, 0, 0, NO_FIELD},
    '{MAXC, MAXC, MAXC, 0, 1, 0, NO_FIELD},
    // path starts on the observation point
    '{0, 0, 0, 1, 0, 0, NO_FIELD},
    '{ONE, 2 * ONE, 0, 0, 1, 1, SING_ONLY},
    // restart mid-path drops the earlier sums
    '{ONE, 0, 0, 1, 0, 0, NO_FIELD},
    '{-ONE, 3 * ONE, ONE, 0, 0, 0, NO_FIELD},
    '{0, ONE, 0, 1, 0, 0, NO_FIELD},
    '{0, 0, ONE, 0, 1, 0, NO_FIELD},
    // mixed extremes per axis
    '{MAXC, 0, MINC, 1, 0, 0, NO_FIELD},
    '{MINC, MAXC, 0, 0, 0, 0, NO_FIELD},
    '{0, MINC, MAXC, 0, 1, 0, NO_FIELD}
  };

  initial begin
    cur_amp = 32'sh0001_0000;
    for (int i = 0; i < 3; i++) begin
      obs_pt[i] = 0;
      prev_v[i] = 0;
    end
    have_prev = 1'b0;
    clear_path();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values first, then the same table at full current swing and a moved observation point
    foreach (directed[i]) send_vertex(directed[i]);
    wait_idle();
    write_config(32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_0000);
    foreach (directed[i]) begin
      vertex_row_t r;
      r = directed[i];
      r.known = 1'b0;
      send_vertex(r);
    end
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        1: write_config(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        2: write_config(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        NUM_PHASES - 1: write_config(32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                                     32'h0000_0000);
        default: write_config($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      calm = (ph == NUM_PHASES - 1);
      for (int n = 0; n < RAND_PATHS_PER_PHASE; n++) random_path();
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/smfs_pkg.sv
design/smfs_mac.sv
design/smfs_dsu.sv
design/segment_magnetic_field_sum.sv
tb/sv/tb.sv
